[sv/gradient_noise_turbulence_defines.svh]
// ---------------------------------------------------------------------------
// gradient_noise_turbulence_defines.svh
// Assertion macros used by the noise block.
// ---------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_TURBULENCE_DEFINES_SVH
`define GRADIENT_NOISE_TURBULENCE_DEFINES_SVH

// implication checked on every edge outside reset
`define GNT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the following cycle
`define GNT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/gnt_pkg.sv]
// ---------------------------------------------------------------------------
// gnt_pkg
// Shared constants and types of the gradient noise block.
// ---------------------------------------------------------------------------
package gnt_pkg;

  localparam int TABLE_SIZE_DEF  = 256;
  localparam int MAX_OCTAVES_DEF = 8;
  localparam int FRAC_BITS_DEF   = 16;

  localparam logic [1:0] FUNC_GRAD = 2'd0;
  localparam logic [1:0] FUNC_PERM = 2'd1;
  localparam logic [1:0] FUNC_EVAL = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam int REG_OCTAVES = 0;
  localparam int REG_TURB    = 1;

  // controller to datapath
  typedef struct packed {
    logic load_pos;    // capture position, clear accumulator
    logic start_oct;   // begin one octave
    logic double_pos;  // shift position left after an octave
    logic finish;      // saturate and present result
  } gnt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic oct_done;
  } gnt_sts_t;

endpackage

[sv/gnt_ctrl.sv]
// ---------------------------------------------------------------------------
// gnt_ctrl
// Sequencer: walks the octaves of one evaluate item.
// ---------------------------------------------------------------------------
`include "gradient_noise_turbulence_defines.svh"

module gnt_ctrl #(
  parameter int MAX_OCTAVES = gnt_pkg::MAX_OCTAVES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             eval_go,
  input  logic [3:0]       octave_count,
  input  logic             turb_mode,
  input  gnt_pkg::gnt_sts_t sts,
  output gnt_pkg::gnt_cmd_t cmd,
  output logic             busy,
  output logic [4:0]       octave
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_OCT  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [4:0] oct_r, oct_nxt;
  logic [4:0] num_r, num_nxt;
  logic [4:0] eff_num;

  always_comb begin
    if (turb_mode == 1'b0) begin
      eff_num = 5'd1;
    end else if ({1'b0, octave_count} > 5'(MAX_OCTAVES)) begin
      eff_num = 5'(MAX_OCTAVES);
    end else begin
      eff_num = {1'b0, octave_count};
    end
  end

  always_comb begin
    state_nxt = state_r;
    oct_nxt   = oct_r;
    num_nxt   = num_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (eval_go) begin
          cmd.load_pos = 1'b1;
          oct_nxt      = '0;
          num_nxt      = eff_num;
          state_nxt    = (eff_num == 5'd0) ? ST_DONE : ST_OCT;
        end
      end
      ST_OCT: begin
        cmd.start_oct = 1'b1;
        state_nxt     = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts.oct_done) begin
          cmd.double_pos = 1'b1;
          oct_nxt        = oct_r + 5'd1;
          state_nxt      = (oct_r + 5'd1 == num_r) ? ST_DONE : ST_OCT;
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      oct_r   <= '0;
      num_r   <= '0;
    end else begin
      state_r <= state_nxt;
      oct_r   <= oct_nxt;
      num_r   <= num_nxt;
    end
  end

  assign busy   = (state_r != ST_IDLE);
  assign octave = oct_r;

  `GNT_ASSERT_NEXT(a_go_busy, eval_go && !busy, busy, "evaluate did not start")
  `GNT_ASSERT_IMP(a_oct_range, busy, oct_r <= 5'(MAX_OCTAVES), "octave beyond limit")
  `GNT_ASSERT_NEXT(a_done_idle, cmd.finish, !busy, "did not return to idle")

endmodule

[sv/gnt_datapath.sv]
// ---------------------------------------------------------------------------
// gnt_datapath
// Table memories, fade, eight corner terms through one shared unit, octave
// accumulation and saturation.
// ---------------------------------------------------------------------------
`include "gradient_noise_turbulence_defines.svh"

module gnt_datapath #(
  parameter int TABLE_SIZE = gnt_pkg::TABLE_SIZE_DEF,
  parameter int FRAC_BITS  = gnt_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_grad,
  input  logic                wr_perm,
  input  logic [1:0]          wr_axis,
  input  logic [7:0]          wr_index,
  input  logic signed [15:0]  wr_gx,
  input  logic signed [15:0]  wr_gy,
  input  logic signed [15:0]  wr_gz,
  input  logic [7:0]          wr_perm_val,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic                turb_mode,
  input  logic [4:0]          octave,
  input  gnt_pkg::gnt_cmd_t   cmd,
  output gnt_pkg::gnt_sts_t   sts,
  output logic                res_valid,
  output logic signed [16:0]  res_value
);

  localparam int TW  = $clog2(TABLE_SIZE);
  localparam int F   = FRAC_BITS;
  localparam int HW  = F + 1;
  localparam int ACW = 48;

  // memories
  logic [47:0] grad_mem [TABLE_SIZE];
  logic [7:0]  px_mem [TABLE_SIZE];
  logic [7:0]  py_mem [TABLE_SIZE];
  logic [7:0]  pz_mem [TABLE_SIZE];

  logic [TW-1:0] wr_idx;
  assign wr_idx = TW'(wr_index);

  always_ff @(posedge clk) begin
    if (wr_grad) begin
      grad_mem[wr_idx] <= {wr_gx, wr_gy, wr_gz};
    end
    if (wr_perm && wr_axis == gnt_pkg::AXIS_X) begin
      px_mem[wr_idx] <= wr_perm_val;
    end
    if (wr_perm && wr_axis == gnt_pkg::AXIS_Y) begin
      py_mem[wr_idx] <= wr_perm_val;
    end
    if (wr_perm && wr_axis == gnt_pkg::AXIS_Z) begin
      pz_mem[wr_idx] <= wr_perm_val;
    end
  end

  // position and octave state
  logic [31:0] px_r, py_r, pz_r;
  logic signed [ACW-1:0] acc_r;
  logic signed [ACW-1:0] noise_r;
  logic [3:0] step_r;       // 0..7 corner fetch, sequencing below
  logic       run_r;
  logic [3:0] phase_r;      // fade phases
  logic res_valid_r;
  logic signed [16:0] res_r;

  logic [TW-1:0] cx, cy, cz;
  logic [F-1:0]  fx, fy, fz;
  assign cx = px_r[F +: TW];
  assign cy = py_r[F +: TW];
  assign cz = pz_r[F +: TW];
  assign fx = px_r[F-1:0];
  assign fy = py_r[F-1:0];
  assign fz = pz_r[F-1:0];

  // fade: three axes through one multiplier, two multiplies each
  logic [HW-1:0] hx_r, hy_r, hz_r;
  logic [HW-1:0] sq_r;
  logic [F-1:0]  fsel;
  logic [2*HW+1:0] fprod;
  logic [HW+1:0]   fk;
  always_comb begin
    case (phase_r[2:1])
      2'd0:    fsel = fx;
      2'd1:    fsel = fy;
      default: fsel = fz;
    endcase
    fk = (HW+2)'(3) * (HW+2)'(1 << F) - (HW+2)'({fsel, 1'b0});
    if (!phase_r[0]) begin
      fprod = (2*HW+2)'(fsel) * (2*HW+2)'(fsel);
    end else begin
      fprod = (2*HW+2)'(sq_r) * (2*HW+2)'(fk);
    end
  end

  // corner stage registers
  logic [2:0]  cs_r;        // corner being fetched
  logic        c1_v_r, c2_v_r, c3_v_r, c4_v_r;
  logic [2:0]  c1_c_r, c2_c_r, c3_c_r;
  logic [7:0]  pxv_r, pyv_r, pzv_r;
  logic [47:0] g_r;
  logic signed [ACW-1:0] dot_r;
  logic signed [ACW-1:0] dot_d_r;   // dot product aligned with w_r
  logic [HW-1:0] wxy_r;
  logic [HW-1:0] w_r;
  logic signed [ACW-1:0] term_r;
  logic        t_v_r;
  logic [3:0]  tcount_r;

  logic [TW-1:0] ax, ay, az, gi;
  assign ax = cx + TW'(cs_r[2]);
  assign ay = cy + TW'(cs_r[1]);
  assign az = cz + TW'(cs_r[0]);
  assign gi = TW'(pxv_r ^ pyv_r ^ pzv_r);

  logic [HW-1:0] wx2, wy2, wz2;
  assign wx2 = c2_c_r[2] ? hx_r : HW'(1 << F) - hx_r;
  assign wy2 = c2_c_r[1] ? hy_r : HW'(1 << F) - hy_r;
  assign wz2 = c3_c_r[0] ? hz_r : HW'(1 << F) - hz_r;

  logic signed [F+1:0] ox, oy, oz;
  assign ox = $signed({2'b00, fx}) - (c2_c_r[2] ? (F+2)'(1 << F) : '0);
  assign oy = $signed({2'b00, fy}) - (c2_c_r[1] ? (F+2)'(1 << F) : '0);
  assign oz = $signed({2'b00, fz}) - (c2_c_r[0] ? (F+2)'(1 << F) : '0);

  logic signed [ACW-1:0] gxe, gye, gze, oxe, oye, oze;
  assign gxe = ACW'($signed(g_r[47:32]));
  assign gye = ACW'($signed(g_r[31:16]));
  assign gze = ACW'($signed(g_r[15:0]));
  assign oxe = ACW'(ox);
  assign oye = ACW'(oy);
  assign oze = ACW'(oz);

  logic signed [ACW-1:0] dsum;
  assign dsum = gxe * oxe + gye * oye + gze * oze;

  logic [2*HW-1:0] wxy_full, w_full;
  assign wxy_full = wx2 * wy2;
  assign w_full   = wxy_r * wz2;

  logic signed [ACW-1:0] dot14, tprod;
  assign dot14 = dot_d_r >>> F;
  assign tprod = dot14 * $signed({1'b0, w_r});

  logic fade_busy;
  assign fade_busy = run_r && (phase_r < 4'd6);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      phase_r     <= '0;
      step_r      <= '0;
      c1_v_r      <= 1'b0;
      c2_v_r      <= 1'b0;
      c3_v_r      <= 1'b0;
      c4_v_r      <= 1'b0;
      t_v_r       <= 1'b0;
      tcount_r    <= '0;
      res_valid_r <= 1'b0;
      cs_r        <= '0;
    end else begin
      res_valid_r <= 1'b0;
      if (cmd.start_oct) begin
        run_r    <= 1'b1;
        phase_r  <= '0;
        step_r   <= '0;
        tcount_r <= '0;
        cs_r     <= '0;
      end else if (fade_busy) begin
        phase_r <= phase_r + 4'd1;
      end else if (run_r && step_r < 4'd8) begin
        cs_r   <= cs_r + 3'd1;
        step_r <= step_r + 4'd1;
      end
      // memory read latency: perm read registered, then gradient read
      c1_v_r <= run_r && !fade_busy && step_r < 4'd8 && !cmd.start_oct;
      c1_c_r <= cs_r;
      c2_v_r <= c1_v_r;
      c2_c_r <= c1_c_r;
      c3_v_r <= c2_v_r;
      c3_c_r <= c2_c_r;
      c4_v_r <= c3_v_r;
      t_v_r  <= c4_v_r;
      if (t_v_r) begin
        tcount_r <= tcount_r + 4'd1;
        if (tcount_r == 4'd7) begin
          run_r <= 1'b0;
        end
      end
      if (cmd.finish) begin
        res_valid_r <= 1'b1;
      end
    end
  end

  // payload registers
  logic [ACW-1:0] sq_shift, h_shift;
  assign sq_shift = ACW'(fprod >> F);
  assign h_shift  = ACW'(fprod >> F);

  logic signed [ACW-1:0] noise_sum, oct_add, acc_abs;
  assign noise_sum = noise_r + term_r;
  assign oct_add   = noise_sum >>> octave;
  assign acc_abs   = (acc_r < 0) ? -acc_r : acc_r;

  always_ff @(posedge clk) begin
    if (cmd.load_pos) begin
      px_r  <= pos_x;
      py_r  <= pos_y;
      pz_r  <= pos_z;
      acc_r <= '0;
    end else if (cmd.double_pos) begin
      px_r <= {px_r[30:0], 1'b0};
      py_r <= {py_r[30:0], 1'b0};
      pz_r <= {pz_r[30:0], 1'b0};
    end
    if (fade_busy) begin
      if (!phase_r[0]) begin
        sq_r <= HW'(sq_shift);
      end else begin
        case (phase_r[2:1])
          2'd0:    hx_r <= HW'(h_shift);
          2'd1:    hy_r <= HW'(h_shift);
          default: hz_r <= HW'(h_shift);
        endcase
      end
    end
    pxv_r <= px_mem[ax];
    pyv_r <= py_mem[ay];
    pzv_r <= pz_mem[az];
    g_r   <= grad_mem[gi];
    dot_r <= dsum;
    dot_d_r <= dot_r;
    wxy_r <= HW'(wxy_full >> F);
    w_r   <= HW'(w_full >> F);
    term_r <= tprod >>> F;
    if (cmd.start_oct) begin
      noise_r <= '0;
    end else if (t_v_r) begin
      noise_r <= noise_sum;
      if (tcount_r == 4'd7) begin
        acc_r <= acc_r + oct_add;
      end
    end
    if (cmd.finish) begin
      if (turb_mode) begin
        res_r <= (acc_abs > ACW'(65535)) ? 17'sd65535 : 17'(acc_abs);
      end else if (acc_r > ACW'(65535)) begin
        res_r <= 17'sd65535;
      end else if (acc_r < -ACW'(65536)) begin
        res_r <= -17'sd65536;
      end else begin
        res_r <= 17'(acc_r);
      end
    end
  end

  assign sts.oct_done = t_v_r && (tcount_r == 4'd7);
  assign res_valid = res_valid_r;
  assign res_value = res_r;

  `GNT_ASSERT_NEXT(a_res_pulse, res_valid_r, !res_valid_r, "result held over one cycle")
  `GNT_ASSERT_IMP(a_no_start_run, cmd.start_oct, !run_r, "octave restarted while running")
  `GNT_ASSERT_IMP(a_term_count, t_v_r, run_r, "corner term outside an octave")

endmodule

[sv/gradient_noise_turbulence.sv]
// ---------------------------------------------------------------------------
// gradient_noise_turbulence
// Fixed-point 3D gradient noise with octave turbulence.
// ---------------------------------------------------------------------------
// Load items (gradient or permutation writes) give no result. An evaluate
// item keeps busy high while it walks its octaves (one octave outside
// turbulence mode, none when the count is zero): each octave takes a start
// step, six fade multiplies, eight corners read one a cycle, and a drain of
// the shared dot/weight pipeline. The result appears on out_noise_value for
// one cycle with out_valid, in the same cycle that busy falls; the receiver
// cannot stall it. Tables must be written before they are read.

module gradient_noise_turbulence #(
  parameter int TABLE_SIZE  = gnt_pkg::TABLE_SIZE_DEF,
  parameter int MAX_OCTAVES = gnt_pkg::MAX_OCTAVES_DEF,
  parameter int FRAC_BITS   = gnt_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic [1:0]         in_table_axis,
  input  logic [7:0]         in_entry_index,
  input  logic signed [15:0] in_grad_x,
  input  logic signed [15:0] in_grad_y,
  input  logic signed [15:0] in_grad_z,
  input  logic [7:0]         in_perm_entry,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  output logic               out_valid,
  output logic signed [16:0] out_noise_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [3:0] octaves_r;
  logic       turb_r;
  logic       acc;
  logic       ctrl_busy;
  logic [4:0] octave;
  gnt_pkg::gnt_cmd_t cmd;
  gnt_pkg::gnt_sts_t sts;

  assign pready = 1'b1;
  assign acc    = start && !busy;
  assign busy   = ctrl_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octaves_r <= 4'd7;
      turb_r    <= 1'b1;
    end else if (psel && penable && pwrite) begin
      if (paddr == 3'(4 * gnt_pkg::REG_OCTAVES)) begin
        octaves_r <= pwdata[3:0];
      end else if (paddr == 3'(4 * gnt_pkg::REG_TURB)) begin
        turb_r <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr == 3'(4 * gnt_pkg::REG_OCTAVES)) begin
      prdata = {28'd0, octaves_r};
    end else if (paddr == 3'(4 * gnt_pkg::REG_TURB)) begin
      prdata = {31'd0, turb_r};
    end else begin
      prdata = '0;
    end
  end

  gnt_ctrl #(.MAX_OCTAVES(MAX_OCTAVES)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .eval_go      (acc && in_func == gnt_pkg::FUNC_EVAL),
    .octave_count (octaves_r),
    .turb_mode    (turb_r),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (ctrl_busy),
    .octave       (octave)
  );

  gnt_datapath #(.TABLE_SIZE(TABLE_SIZE), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_grad     (acc && in_func == gnt_pkg::FUNC_GRAD),
    .wr_perm     (acc && in_func == gnt_pkg::FUNC_PERM),
    .wr_axis     (in_table_axis),
    .wr_index    (in_entry_index),
    .wr_gx       (in_grad_x),
    .wr_gy       (in_grad_y),
    .wr_gz       (in_grad_z),
    .wr_perm_val (in_perm_entry),
    .pos_x       (in_pos_x),
    .pos_y       (in_pos_y),
    .pos_z       (in_pos_z),
    .turb_mode   (turb_r),
    .octave      (octave),
    .cmd         (cmd),
    .sts         (sts),
    .res_valid   (out_valid),
    .res_value   (out_noise_value)
  );

endmodule
